### src/bas_pkg.sv
package bas_pkg;

  // number of BCD digit lanes and packing
  localparam int MAX_DIGITS  = 16;
  localparam int DIGIT_W     = 4;
  localparam int OPERAND_W   = 64;
  localparam int CNT_W       = 5;
  localparam int GROUP_SIZE  = 4;
  localparam int NUM_GROUPS  = (MAX_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;

  // operation codes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // what one digit lane hands to the merge stage
  typedef struct packed {
    logic [DIGIT_W-1:0] sum0;    // digit with no carry/borrow in
    logic [DIGIT_W-1:0] sum1;    // digit with carry/borrow in
    logic               gen;     // carry/borrow out regardless of carry in
    logic               prop;    // carry/borrow out when carry in is set
    logic               bad;     // operand digit above nine
    logic               in_use;  // digit takes part
    logic [DIGIT_W-1:0] keep;    // first operand digit, zero when unused
  } lane_t;

endpackage

### src/bas_lane.sv
module bas_lane
  import bas_pkg::*;
(
  input  logic               op,
  input  logic [DIGIT_W-1:0] digit_a,
  input  logic [DIGIT_W-1:0] digit_b,
  input  logic               in_use,
  output lane_t              lane
);

  logic [DIGIT_W:0] add0;
  logic [DIGIT_W:0] add1;
  logic [DIGIT_W:0] sub0;
  logic [DIGIT_W:0] sub1;
  logic [DIGIT_W:0] a_ext;
  logic [DIGIT_W:0] a_plus_ten;

  // both carry-in variants of the digit sum and subtrahend
  assign a_ext      = {1'b0, digit_a};
  assign a_plus_ten = a_ext + (DIGIT_W+1)'(10);
  assign add0       = a_ext + {1'b0, digit_b};
  assign add1       = add0 + (DIGIT_W+1)'(1);
  assign sub0       = {1'b0, digit_b};
  assign sub1       = sub0 + (DIGIT_W+1)'(1);

  // per-digit result for carry in of zero and one
  always_comb begin
    lane.bad    = in_use && ((digit_a > DIGIT_W'(9)) || (digit_b > DIGIT_W'(9)));
    lane.in_use = in_use;
    lane.keep   = in_use ? digit_a : '0;
    unique case (op)
      OP_ADD: begin
        if (add0 > (DIGIT_W+1)'(9)) begin
          lane.sum0 = DIGIT_W'(add0 - (DIGIT_W+1)'(10));
          lane.gen  = 1'b1;
        end else begin
          lane.sum0 = add0[DIGIT_W-1:0];
          lane.gen  = 1'b0;
        end
        if (add1 > (DIGIT_W+1)'(9)) begin
          lane.sum1 = DIGIT_W'(add1 - (DIGIT_W+1)'(10));
          lane.prop = 1'b1;
        end else begin
          lane.sum1 = add1[DIGIT_W-1:0];
          lane.prop = 1'b0;
        end
      end
      default: begin
        if (sub0 > a_ext) begin
          lane.sum0 = DIGIT_W'(a_plus_ten - sub0);
          lane.gen  = 1'b1;
        end else begin
          lane.sum0 = DIGIT_W'(a_ext - sub0);
          lane.gen  = 1'b0;
        end
        if (sub1 > a_ext) begin
          lane.sum1 = DIGIT_W'(a_plus_ten - sub1);
          lane.prop = 1'b1;
        end else begin
          lane.sum1 = DIGIT_W'(a_ext - sub1);
          lane.prop = 1'b0;
        end
      end
    endcase
    // unused digits pass the carry straight through
    if (!in_use) begin
      lane.gen  = 1'b0;
      lane.prop = 1'b1;
    end
  end

endmodule

### src/bas_merge.sv
module bas_merge
  import bas_pkg::*;
(
  input  lane_t                lanes [MAX_DIGITS],
  output logic [OPERAND_W-1:0] result_nxt,
  output status_t              status_nxt
);

  logic                  grp_gen  [NUM_GROUPS];
  logic                  grp_prop [NUM_GROUPS];
  logic                  grp_cin  [NUM_GROUPS+1];
  logic                  lane_cin [MAX_DIGITS];
  logic [OPERAND_W-1:0]  sum_word;
  logic [OPERAND_W-1:0]  keep_word;
  logic                  any_bad;

  // group generate/propagate over each run of lanes
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_gen[g]  = 1'b0;
      grp_prop[g] = 1'b1;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MAX_DIGITS) begin
          grp_gen[g]  = lanes[g*GROUP_SIZE+k].gen |
                        (lanes[g*GROUP_SIZE+k].prop & grp_gen[g]);
          grp_prop[g] = lanes[g*GROUP_SIZE+k].gen |
                        (lanes[g*GROUP_SIZE+k].prop & grp_prop[g]);
        end
      end
    end
  end

  // carry across groups, then into each lane
  always_comb begin
    grp_cin[0] = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_cin[g+1] = grp_cin[g] ? grp_prop[g] : grp_gen[g];
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      lane_cin[i] = 1'b0;
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MAX_DIGITS) begin
          if (k == 0) begin
            lane_cin[g*GROUP_SIZE+k] = grp_cin[g];
          end else begin
            lane_cin[g*GROUP_SIZE+k] = lane_cin[g*GROUP_SIZE+k-1] ?
                                       lanes[g*GROUP_SIZE+k-1].prop :
                                       lanes[g*GROUP_SIZE+k-1].gen;
          end
        end
      end
    end
  end

  // pick digits and collect errors
  always_comb begin
    sum_word  = '0;
    keep_word = '0;
    any_bad   = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (lanes[i].in_use) begin
        sum_word[i*DIGIT_W +: DIGIT_W] = lane_cin[i] ? lanes[i].sum1 : lanes[i].sum0;
      end
      keep_word[i*DIGIT_W +: DIGIT_W] = lanes[i].keep;
      any_bad = any_bad | lanes[i].bad;
    end
  end

  // bad digit wins over overflow
  always_comb begin
    priority if (any_bad) begin
      status_nxt = ST_BAD_DIGIT;
      result_nxt = keep_word;
    end else if (grp_cin[NUM_GROUPS]) begin
      status_nxt = ST_OVERFLOW;
      result_nxt = keep_word;
    end else begin
      status_nxt = ST_OK;
      result_nxt = sum_word;
    end
  end

endmodule

### src/bcd_add_subtract.sv
// Packed BCD adder/subtractor. Each input transaction carries two sixteen-digit
// BCD operands and an add/subtract select; one result transaction comes back with
// the sum or difference and a status (ok, bad digit or overflow). Only the lowest
// cfg digits take part (values above sixteen count as sixteen); higher result
// digits are zero, and on any error the first operand's digits in use are
// returned. The block takes one transaction per cycle unless the output stalls:
// one digit lane per BCD digit works out both carry-in cases in the first stage,
// and a two-level carry lookahead across the lanes picks the digits in the second.
// The output register lets a new transaction enter while a result waits.
module bcd_add_subtract
  import bas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [2*OPERAND_W-1:0] in_tdata,   // first_operand, second_operand
  input  logic                   in_tuser,   // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OPERAND_W-1:0]   out_tdata,  // result_digits
  output logic [1:0]             out_tuser,  // status
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data    // digits_in_use
);

  logic [CNT_W-1:0]     digits_r;
  logic [CNT_W-1:0]     digits_eff;
  lane_t                lane_nxt [MAX_DIGITS];
  lane_t                lane_r   [MAX_DIGITS];
  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic [OPERAND_W-1:0] out_data_r;
  status_t              out_status_r;
  logic [OPERAND_W-1:0] result_nxt;
  status_t              status_nxt;
  logic                 out_adv;
  logic                 s1_adv;

  // digit count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= CNT_W'(MAX_DIGITS);
    end else if (cfg_valid && cfg_ready) begin
      digits_r <= cfg_data;
    end
  end

  assign digits_eff = (digits_r > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digits_r;

  // one lane per digit
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_lane
    bas_lane u_lane (
      .op      (in_tuser),
      .digit_a (in_tdata[i*DIGIT_W +: DIGIT_W]),
      .digit_b (in_tdata[OPERAND_W + i*DIGIT_W +: DIGIT_W]),
      .in_use  (CNT_W'(i) < digits_eff),
      .lane    (lane_nxt[i])
    );
  end

  // pipeline flow control
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // lane stage register
  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      lane_r <= lane_nxt;
    end
  end

  bas_merge u_merge (
    .lanes      (lane_r),
    .result_nxt (result_nxt),
    .status_nxt (status_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r   <= result_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
